// ===== rtl/tod_pkg.sv =====
// Shared types, constants and constant-divide helpers for the time-of-day clock.
// No dependencies; used by every module of the block.
package tod_pkg;

   localparam int TS_W        = 32;   // timestamp width
   localparam int SECS_W      = 23;   // whole seconds in one timestamp span
   localparam int MQ_W        = 17;   // minutes in one span
   localparam int HQ_W        = 11;   // hours in one span
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 8;

   localparam int MS_PER_S    = 1000;
   localparam int SEC_PER_MIN = 60;
   localparam int MIN_PER_HR  = 60;
   localparam int HR_PER_DAY  = 24;

   // floor(2^32/1000), floor(2^28/60), floor(2^16/24): estimate is q or q-1
   localparam logic [22:0] RECIP_1000 = 23'd4294967;
   localparam logic [22:0] RECIP_60   = 23'd4473924;
   localparam logic [11:0] RECIP_24   = 12'd2730;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_SET  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_HOUR   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_MINUTE = 8'd1;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } time_type;

   // item leaving the elapsed-time stage
   typedef struct packed {
      logic              mode;
      time_type          set_time;
      logic [SECS_W-1:0] secs;
   } step_type;

   // item leaving the split pipeline: loaded time or h/m/s to add
   typedef struct packed {
      logic     mode;
      time_type tval;
   } delta_type;

   typedef struct packed {
      logic [MQ_W-1:0] quo;
      logic [5:0]      rem;
   } div60_type;

   function automatic div60_type div60(input logic [SECS_W-1:0] x);
      logic [45:0]       prod;
      logic [MQ_W-1:0]   q;
      logic [SECS_W:0]   q60;
      logic [SECS_W-1:0] r;
      div60_type         res;
      prod = x * RECIP_60;
      q    = prod[28+MQ_W-1:28];
      q60  = {{(SECS_W+1-MQ_W-6){1'b0}}, q, 6'b0} - {{(SECS_W+1-MQ_W-2){1'b0}}, q, 2'b0};
      r    = x - q60[SECS_W-1:0];
      if (r >= SECS_W'(SEC_PER_MIN)) begin
         res.quo = q + MQ_W'(1);
         res.rem = 6'(r - SECS_W'(SEC_PER_MIN));
      end else begin
         res.quo = q;
         res.rem = r[5:0];
      end
      return res;
   endfunction

   function automatic logic [4:0] mod24(input logic [HQ_W-1:0] x);
      logic [22:0]     prod;
      logic [6:0]      q;
      logic [HQ_W-1:0] q24;
      logic [HQ_W-1:0] r;
      prod = x * RECIP_24;
      q    = prod[22:16];
      q24  = HQ_W'({q, 4'b0}) + HQ_W'({q, 3'b0});
      r    = x - q24;
      if (r >= HQ_W'(HR_PER_DAY))
         r = r - HQ_W'(HR_PER_DAY);
      return r[4:0];
   endfunction

endpackage

// ===== rtl/tod_elapsed.sv =====
// Input register and elapsed-seconds stage: holds the millisecond reference,
// splits the timestamp difference into whole seconds. Uses tod_pkg.
module tod_elapsed import tod_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic            in_mode,
   input  logic [TS_W-1:0] in_now,
   input  time_type        in_set,
   output logic            out_valid,
   input  logic            out_ready,
   output step_type        out_step
);

   logic            s0_valid_ff, s0_mode_ff;
   logic [TS_W-1:0] s0_now_ff;
   time_type        s0_set_ff;
   logic [TS_W-1:0] ref_ff, ref_in;
   logic            s1_valid_ff;
   step_type        s1_step_ff, s1_step_in;

   logic              s0_adv, s1_adv;
   logic [TS_W-1:0]   delta, rem_est, rem;
   logic [54:0]       prod;
   logic [SECS_W-1:0] q_est, secs;
   logic [TS_W:0]     q_ext, q1000;
   time_type          set_clamped;

   assign s1_adv   = !s1_valid_ff || out_ready;
   assign s0_adv   = !s0_valid_ff || s1_adv;
   assign in_ready = s0_adv;

   always_comb begin
      delta   = s0_now_ff - ref_ff;
      prod    = delta * RECIP_1000;
      q_est   = prod[32+SECS_W-1:32];
      q_ext   = {{(TS_W+1-SECS_W){1'b0}}, q_est};
      // q * 1000 = q*1024 - q*16 - q*8
      q1000   = (q_ext << 10) - (q_ext << 4) - (q_ext << 3);
      rem_est = delta - q1000[TS_W-1:0];
      if (rem_est >= TS_W'(MS_PER_S)) begin
         secs = q_est + SECS_W'(1);
         rem  = rem_est - TS_W'(MS_PER_S);
      end else begin
         secs = q_est;
         rem  = rem_est;
      end

      set_clamped.hours   = (s0_set_ff.hours > 5'(HR_PER_DAY - 1)) ?
                            5'(HR_PER_DAY - 1) : s0_set_ff.hours;
      set_clamped.minutes = (s0_set_ff.minutes > 6'(MIN_PER_HR - 1)) ?
                            6'(MIN_PER_HR - 1) : s0_set_ff.minutes;
      set_clamped.seconds = (s0_set_ff.seconds > 6'(SEC_PER_MIN - 1)) ?
                            6'(SEC_PER_MIN - 1) : s0_set_ff.seconds;

      // reference lands on the last whole-second boundary: no drift
      ref_in = (s0_mode_ff == MODE_SET) ? s0_now_ff : (s0_now_ff - rem);

      s1_step_in.mode     = s0_mode_ff;
      s1_step_in.set_time = set_clamped;
      s1_step_in.secs     = (s0_mode_ff == MODE_SET) ? '0 : secs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         ref_ff      <= '0;
      end else begin
         if (s0_adv)
            s0_valid_ff <= in_valid;
         if (s1_adv)
            s1_valid_ff <= s0_valid_ff;
         if (s0_valid_ff && s1_adv)
            ref_ff <= ref_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s0_adv) begin
         s0_mode_ff <= in_mode;
         s0_now_ff  <= in_now;
         s0_set_ff  <= in_set;
      end
      if (s0_valid_ff && s1_adv)
         s1_step_ff <= s1_step_in;
   end

   assign out_valid = s1_valid_ff;
   assign out_step  = s1_step_ff;

endmodule

// ===== rtl/tod_split.sv =====
// Three-stage pipeline that turns a count of seconds into hours (mod 24),
// minutes and seconds. Stateless apart from its stage registers. Uses tod_pkg.
module tod_split import tod_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  step_type  in_step,
   output logic      out_valid,
   input  logic      out_ready,
   output delta_type out_delta
);

   logic            a_valid_ff, b_valid_ff, c_valid_ff;
   logic            a_mode_ff, b_mode_ff;
   time_type        a_set_ff, b_set_ff;
   logic [5:0]      a_rs_ff, b_rs_ff;
   logic [MQ_W-1:0] a_mq_ff;
   logic [5:0]      b_rm_ff;
   logic [HQ_W-1:0] b_hq_ff;
   delta_type       c_delta_ff, c_delta_in;

   logic      a_adv, b_adv, c_adv;
   div60_type sec_div, min_div;

   assign c_adv    = !c_valid_ff || out_ready;
   assign b_adv    = !b_valid_ff || c_adv;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   always_comb begin
      sec_div = div60(in_step.secs);
      min_div = div60({{(SECS_W-MQ_W){1'b0}}, a_mq_ff});

      c_delta_in.mode = b_mode_ff;
      if (b_mode_ff == MODE_SET) begin
         c_delta_in.tval = b_set_ff;
      end else begin
         c_delta_in.tval.hours   = mod24(b_hq_ff);
         c_delta_in.tval.minutes = b_rm_ff;
         c_delta_in.tval.seconds = b_rs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_adv)
            a_valid_ff <= in_valid;
         if (b_adv)
            b_valid_ff <= a_valid_ff;
         if (c_adv)
            c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_adv) begin
         a_mode_ff <= in_step.mode;
         a_set_ff  <= in_step.set_time;
         a_rs_ff   <= sec_div.rem;
         a_mq_ff   <= sec_div.quo;
      end
      if (a_valid_ff && b_adv) begin
         b_mode_ff <= a_mode_ff;
         b_set_ff  <= a_set_ff;
         b_rs_ff   <= a_rs_ff;
         b_rm_ff   <= min_div.rem;
         b_hq_ff   <= min_div.quo[HQ_W-1:0];
      end
      if (b_valid_ff && c_adv)
         c_delta_ff <= c_delta_in;
   end

   assign out_valid = c_valid_ff;
   assign out_delta = c_delta_ff;

endmodule

// ===== rtl/time_of_day_clock_with_alarm.sv =====
// Time-of-day clock with alarm, driven by a free-running millisecond timestamp.
// Top level: tod_elapsed -> tod_split -> time accumulate / alarm result stage.
// Uses tod_pkg.
//
// Each item on req_ is either a tick (tuser 0) carrying a millisecond timestamp,
// or a set (tuser 1) that loads hh:mm:ss (clamped to 23:59:59) and takes its
// timestamp as the new reference. A tick adds the whole seconds elapsed since
// the reference and moves the reference by exactly that many seconds, so
// fractions carry over to later ticks. Every item returns one rsp_ item with the
// time after it, alarm_hit (time equals alarm_hour:alarm_minute:00) and the
// sticky alarm_latched flag, which a write to either alarm register clears.
// The block takes one item per clock unless rsp_tready holds it back; an item
// passes the input register, seconds divide, two divide-by-60 stages, hour fold
// and time accumulate on its way to rsp_. The timestamp reference loop and the
// time-of-day accumulate each close via combinational logic, setting the rate.
// Alarm registers are written through csr_, which is always ready.
module time_of_day_clock_with_alarm import tod_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] now_ms, [36:32] set_hours, [42:37] set_minutes, [48:43] set_seconds
   input  logic [55:0]           req_tdata,
   // [0] mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [4:0] hours, [10:5] minutes, [16:11] seconds, [17] alarm_hit,
   // [18] alarm_latched
   output logic [23:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic      el_valid, el_ready;
   step_type  el_step;
   logic      sp_valid, sp_ready;
   delta_type sp_delta;
   time_type  req_set;

   logic       rsp_valid_ff;
   time_type   rsp_time_ff;
   logic       rsp_hit_ff, rsp_latched_ff;
   time_type   time_ff, time_in;
   logic [4:0] alarm_hour_ff;
   logic [5:0] alarm_minute_ff;
   logic       alarm_flag_ff;

   logic       out_adv, take, csr_wr, csr_alarm;
   logic [6:0] s_sum, m_sum;
   logic [5:0] h_sum;
   logic       s_carry, m_carry, hit;

   assign req_set.hours   = req_tdata[36:32];
   assign req_set.minutes = req_tdata[42:37];
   assign req_set.seconds = req_tdata[48:43];

   tod_elapsed u_elapsed (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_now    (req_tdata[TS_W-1:0]),
      .in_set    (req_set),
      .out_valid (el_valid),
      .out_ready (el_ready),
      .out_step  (el_step)
   );

   tod_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (el_valid),
      .in_ready  (el_ready),
      .in_step   (el_step),
      .out_valid (sp_valid),
      .out_ready (sp_ready),
      .out_delta (sp_delta)
   );

   assign out_adv   = !rsp_valid_ff || rsp_tready;
   assign sp_ready  = out_adv;
   assign take      = sp_valid && out_adv;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign csr_alarm = csr_wr && ((csr_index == CSR_ALARM_HOUR) ||
                                 (csr_index == CSR_ALARM_MINUTE));

   always_comb begin
      s_sum   = {1'b0, time_ff.seconds} + {1'b0, sp_delta.tval.seconds};
      s_carry = (s_sum >= 7'(SEC_PER_MIN));
      m_sum   = {1'b0, time_ff.minutes} + {1'b0, sp_delta.tval.minutes} + {6'b0, s_carry};
      m_carry = (m_sum >= 7'(MIN_PER_HR));
      h_sum   = {1'b0, time_ff.hours} + {1'b0, sp_delta.tval.hours} + {5'b0, m_carry};

      if (sp_delta.mode == MODE_SET) begin
         time_in = sp_delta.tval;
      end else begin
         time_in.seconds = s_carry ? 6'(s_sum - 7'(SEC_PER_MIN)) : s_sum[5:0];
         time_in.minutes = m_carry ? 6'(m_sum - 7'(MIN_PER_HR)) : m_sum[5:0];
         time_in.hours   = (h_sum >= 6'(HR_PER_DAY)) ? 5'(h_sum - 6'(HR_PER_DAY)) :
                           h_sum[4:0];
      end

      hit = (time_in.hours == alarm_hour_ff) && (time_in.minutes == alarm_minute_ff) &&
            (time_in.seconds == 6'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         time_ff         <= '0;
         alarm_hour_ff   <= '0;
         alarm_minute_ff <= '0;
         alarm_flag_ff   <= 1'b0;
      end else begin
         if (out_adv)
            rsp_valid_ff <= sp_valid;
         if (take)
            time_ff <= time_in;
         if (csr_wr && (csr_index == CSR_ALARM_HOUR))
            alarm_hour_ff <= csr_data[4:0];
         if (csr_wr && (csr_index == CSR_ALARM_MINUTE))
            alarm_minute_ff <= csr_data[5:0];
         if (csr_alarm)
            alarm_flag_ff <= 1'b0;
         else if (take && hit)
            alarm_flag_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_time_ff    <= time_in;
         rsp_hit_ff     <= hit;
         rsp_latched_ff <= alarm_flag_ff || hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_latched_ff, rsp_hit_ff, rsp_time_ff.seconds,
                        rsp_time_ff.minutes, rsp_time_ff.hours};

   // time of day never leaves its range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_time_ff.hours < 5'(HR_PER_DAY)) &&
                       (rsp_time_ff.minutes < 6'(MIN_PER_HR)) &&
                       (rsp_time_ff.seconds < 6'(SEC_PER_MIN)))
      else $error("time of day out of range");

   // a hit always shows up in the sticky flag of the same item
   a_hit_latched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> rsp_latched_ff)
      else $error("alarm hit without latched flag");

   // an alarm register write clears the sticky flag
   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_alarm |=> !alarm_flag_ff)
      else $error("alarm write did not clear flag");

   // time of day moves only when an item passes the accumulate stage
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      (!take && !$past(reset)) |=> $stable(time_ff))
      else $error("time of day changed without an item");

endmodule
